@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define THFE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition in one cycle brings a consequence in the next cycle.
`define THFE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/thfe_pkg.sv @@
// Types, codes and helper functions for the TLS hello field extractor.
package thfe_pkg;

   localparam int unsigned FifoDepth = 8;
   localparam int unsigned FifoPtrW  = $clog2(FifoDepth);

   localparam logic [3:0] KIND_CIPHER = 4'd0;
   localparam logic [3:0] KIND_EXT    = 4'd1;
   localparam logic [3:0] KIND_GROUP  = 4'd2;
   localparam logic [3:0] KIND_PFMT   = 4'd3;
   localparam logic [3:0] KIND_SIG    = 4'd4;
   localparam logic [3:0] KIND_SNI    = 4'd5;
   localparam logic [3:0] KIND_ALPN   = 4'd6;
   localparam logic [3:0] KIND_ACCEPT = 4'd7;
   localparam logic [3:0] KIND_REJECT = 4'd8;

   localparam logic [15:0] EXT_SERVER_NAME = 16'd0;
   localparam logic [15:0] EXT_GROUPS      = 16'd10;
   localparam logic [15:0] EXT_POINT_FMTS  = 16'd11;
   localparam logic [15:0] EXT_SIG_ALGS    = 16'd13;
   localparam logic [15:0] EXT_ALPN        = 16'd16;

   localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
   localparam logic [7:0]  HS_CLIENT_HELLO = 8'd1;
   localparam logic [7:0]  HS_SERVER_HELLO = 8'd2;
   localparam logic [15:0] VER_SSL2        = 16'h0002;
   localparam logic [15:0] VER_SSL3        = 16'h0300;
   localparam logic [15:0] VER_TLS12       = 16'h0303;
   localparam logic [15:0] VER_TLS13       = 16'h0304;
   localparam logic [15:0] RANDOM_BYTES    = 16'd32;
   localparam logic [15:0] SNI_MAX_LEN     = 16'd255;

   typedef enum logic [5:0] {
      PH_TYPE, PH_RVER, PH_CLEN, PH_MTYPE, PH_MLEN, PH_HVER, PH_RANDOM,
      PH_SIDLEN, PH_SID, PH_CSLEN, PH_CIPHERS, PH_COMPLEN, PH_COMP, PH_EXTLEN,
      PH_SCIPHER, PH_SCOMP, PH_SEXTLEN, PH_EXTTYPE, PH_EXTLN, PH_EXTSKIP,
      PH_SNI_LIST, PH_SNI_TYPE, PH_SNI_LEN, PH_SNI_NAME, PH_GRP_LEN, PH_GRP,
      PH_PF_LEN, PH_PF, PH_SIG_LEN, PH_SIG, PH_ALPN_LEN, PH_ALPN_SLEN,
      PH_ALPN_STR, PH_DONE
   } phase_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] value;
      logic        is_server;
      logic [15:0] rec_version;
      logic [15:0] hello_version;
      logic        last;
   } item_type;

   // Byte count of a fixed-size header field; zero for counted phases.
   function automatic logic [1:0] fixed_width(phase_type ph);
      logic [1:0] w;
      case (ph)
         PH_TYPE, PH_MTYPE, PH_SIDLEN, PH_COMPLEN, PH_SCOMP, PH_SNI_TYPE,
         PH_PF_LEN, PH_ALPN_SLEN:                                    w = 2'd1;
         PH_RVER, PH_CLEN, PH_HVER, PH_CSLEN, PH_EXTLEN, PH_SCIPHER,
         PH_SEXTLEN, PH_EXTTYPE, PH_EXTLN, PH_SNI_LIST, PH_SNI_LEN,
         PH_GRP_LEN, PH_SIG_LEN, PH_ALPN_LEN:                        w = 2'd2;
         PH_MLEN:                                                    w = 2'd3;
         default:                                                    w = 2'd0;
      endcase
      return w;
   endfunction

   // A GREASE code has equal bytes, each with a low nibble of 0xa.
   function automatic logic is_grease(logic [15:0] v);
      return ((v & 16'h0f0f) == 16'h0a0a) && (v[15:8] == v[7:0]);
   endfunction

endpackage

@@ design/tls_hello_field_extractor.sv @@
// The extractor takes one packet byte per cycle and parses a TLS handshake record that
// holds a ClientHello or ServerHello, producing tagged items (cipher suites, extension
// types, groups, point formats, signature algorithms, SNI bytes, first ALPN name bytes)
// and one accept or reject verdict per packet; items before the verdict are provisional.
// A byte is registered on acceptance, parsed in the next cycle and its zero to two results
// are written into an eight-entry result queue, whose head drives the result port. Bytes
// are taken one per cycle as long as the queue has room for the results of every byte in
// flight; a byte that yields two results, or a stalled result consumer, fills the queue
// and then holds req_ready low until results drain.
module tls_hello_field_extractor
   import thfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_packet,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_item_kind,
   output logic [15:0] rsp_item_value,
   output logic        rsp_hello_is_server,
   output logic [15:0] rsp_record_version,
   output logic [15:0] rsp_hello_version,
   output logic        rsp_verdict_last
);

   logic              stg_valid_ff, stg_valid_in;
   logic [7:0]        stg_byte_ff, stg_byte_in;
   logic              stg_eop_ff, stg_eop_in;
   logic [1:0]        push_cnt;
   item_type          push0;
   item_type          push1;
   logic [FifoPtrW:0] fifo_count;
   logic              fifo_not_empty;
   item_type          head;
   logic [FifoPtrW+1:0] committed;

   // Room is reserved for two results from the staged byte and two from a new one.
   assign committed = {1'b0, fifo_count} + (stg_valid_ff ? (FifoPtrW+2)'(2) : '0) +
                      (FifoPtrW+2)'(2);
   assign req_ready = (committed <= (FifoPtrW+2)'(FifoDepth));

   always_comb begin
      stg_valid_in = req_valid && req_ready;
      stg_byte_in  = req_data_byte;
      stg_eop_in   = req_end_of_packet;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_valid_in) begin
         stg_byte_ff <= stg_byte_in;
         stg_eop_ff  <= stg_eop_in;
      end
   end

   thfe_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step_valid (stg_valid_ff),
      .step_byte  (stg_byte_ff),
      .step_eop   (stg_eop_ff),
      .push_cnt   (push_cnt),
      .push0      (push0),
      .push1      (push1)
   );

   thfe_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push0     (push0),
      .push1     (push1),
      .pop       (rsp_valid && rsp_ready),
      .count     (fifo_count),
      .not_empty (fifo_not_empty),
      .head      (head)
   );

   assign rsp_valid           = fifo_not_empty;
   assign rsp_item_kind       = head.kind;
   assign rsp_item_value      = head.value;
   assign rsp_hello_is_server = head.is_server;
   assign rsp_record_version  = head.rec_version;
   assign rsp_hello_version   = head.hello_version;
   assign rsp_verdict_last    = head.last;

endmodule

@@ design/thfe_rsp_fifo.sv @@
// Result queue that takes up to two items per cycle and delivers one per pop.
module thfe_rsp_fifo
   import thfe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          push_cnt,
   input  item_type            push0,
   input  item_type            push1,
   input  logic                pop,
   output logic [FifoPtrW:0]   count,
   output logic                not_empty,
   output item_type            head
);

   item_type             mem_ff [FifoDepth];
   logic [FifoPtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FifoPtrW:0]    count_ff, count_in;
   logic [FifoPtrW-1:0]  wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FifoPtrW'(push_cnt);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (FifoPtrW+1)'(push_cnt) - (FifoPtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_ptr_next] <= push1;
      end
   end

   assign count     = count_ff;
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

endmodule

@@ design/thfe_parser.sv @@
// Per-byte hello parser: phase register, length counters and item generation.
module thfe_parser
   import thfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_valid,
   input  logic [7:0] step_byte,
   input  logic       step_eop,
   output logic [1:0] push_cnt,
   output item_type   push0,
   output item_type   push1
);

   phase_type          phase_ff, phase_in;
   logic [1:0]         fbc_ff, fbc_in;
   logic [23:0]        acc_ff, acc_in;
   logic signed [17:0] erl_ff, erl_in;
   logic [15:0]        ill_ff, ill_in;
   logic [15:0]        cek_ff, cek_in;
   logic [16:0]        ac_ff, ac_in;
   logic               fap_ff, fap_in;
   logic               srv_ff, srv_in;
   logic [15:0]        rv_ff, rv_in;
   logic [15:0]        hv_ff, hv_in;
   logic               vg_ff, vg_in;
   logic [23:0]        bo_ff, bo_in;
   logic [15:0]        at_ff, at_in;
   logic [15:0]        st_ff, st_in;

   logic [23:0]  acc_new;
   logic [23:0]  v;
   logic [1:0]   fw;
   logic         sf_req;
   phase_type    sf_ph;
   logic         ec_req;
   phase_type    ec_ph;
   logic [15:0]  ec_n;
   logic         owe_req;
   logic [23:0]  owe_val;
   logic         fin_req;
   phase_type    fin_ph;
   logic         fail_now;
   logic         accept_now;
   logic         eop_reject;
   logic         ext_next;
   logic         item_valid;
   logic [3:0]   item_kind;
   logic [15:0]  item_value;
   logic [15:0]  pair_val;
   logic [15:0]  ill_dec;
   logic         verd_valid;
   item_type     it_item;
   item_type     it_verd;

   assign acc_new  = {acc_ff[15:0], step_byte};
   assign v        = acc_new;
   assign fw       = fixed_width(phase_ff);
   assign pair_val = {acc_ff[7:0], step_byte};

   always_comb begin
      phase_in = phase_ff;
      fbc_in   = fbc_ff;
      acc_in   = acc_ff;
      erl_in   = erl_ff;
      ill_in   = ill_ff;
      cek_in   = cek_ff;
      ac_in    = ac_ff;
      fap_in   = fap_ff;
      srv_in   = srv_ff;
      rv_in    = rv_ff;
      hv_in    = hv_ff;
      vg_in    = vg_ff;
      bo_in    = bo_ff;
      at_in    = at_ff;
      st_in    = st_ff;
      sf_req   = 1'b0;
      sf_ph    = PH_TYPE;
      ec_req   = 1'b0;
      ec_ph    = PH_EXTSKIP;
      ec_n     = '0;
      owe_req  = 1'b0;
      owe_val  = '0;
      fin_req  = 1'b0;
      fin_ph   = PH_EXTSKIP;
      fail_now = 1'b0;
      accept_now = 1'b0;
      eop_reject = 1'b0;
      ext_next   = 1'b0;
      item_valid = 1'b0;
      item_kind  = KIND_CIPHER;
      item_value = '0;
      ill_dec    = '0;

      if (step_valid && !vg_ff) begin
         bo_in = (bo_ff != '0) ? bo_ff - 24'd1 : bo_ff;
         if (phase_ff != PH_DONE) begin
            if (fw != 2'd0) begin
               acc_in = acc_new;
               fbc_in = fbc_ff + 2'd1;
               if ((fbc_ff + 2'd1) >= fw) begin
                  case (phase_ff)
                     PH_TYPE: begin
                        if (v != {16'd0, REC_HANDSHAKE}) fail_now = 1'b1;
                        else begin sf_req = 1'b1; sf_ph = PH_RVER; end
                     end
                     PH_RVER: begin
                        rv_in = v[15:0];
                        if (v[15:0] inside {VER_SSL2, [VER_SSL3:VER_TLS12]}) begin
                           sf_req = 1'b1;
                           sf_ph  = PH_CLEN;
                        end else fail_now = 1'b1;
                     end
                     PH_CLEN: begin
                        owe_req = 1'b1; owe_val = v;
                        sf_req = 1'b1; sf_ph = PH_MTYPE;
                     end
                     PH_MTYPE: begin
                        if (v == {16'd0, HS_CLIENT_HELLO}) begin
                           srv_in = 1'b0; sf_req = 1'b1; sf_ph = PH_MLEN;
                        end else if (v == {16'd0, HS_SERVER_HELLO}) begin
                           srv_in = 1'b1; sf_req = 1'b1; sf_ph = PH_MLEN;
                        end else fail_now = 1'b1;
                     end
                     PH_MLEN: begin
                        owe_req = 1'b1; owe_val = v;
                        sf_req = 1'b1; sf_ph = PH_HVER;
                     end
                     PH_HVER: begin
                        hv_in = v[15:0];
                        if ((v[15:0] inside {VER_SSL2, [VER_SSL3:VER_TLS12]}) ||
                            (v[15:0] == VER_TLS13 && !srv_ff)) begin
                           ec_req = 1'b1; ec_ph = PH_RANDOM; ec_n = RANDOM_BYTES;
                        end else fail_now = 1'b1;
                     end
                     PH_SIDLEN: begin
                        owe_req = 1'b1;
                        owe_val = {16'd0, v[7:0]} + (srv_ff ? 24'd5 : 24'd2);
                        ec_req = 1'b1; ec_ph = PH_SID; ec_n = {8'd0, v[7:0]};
                     end
                     PH_CSLEN: begin
                        owe_req = 1'b1; owe_val = {8'd0, v[15:0]} + 24'd1;
                        if (v[15:1] == '0) fail_now = 1'b1;
                        else begin
                           ec_req = 1'b1; ec_ph = PH_CIPHERS; ec_n = {1'b0, v[15:1]};
                        end
                     end
                     PH_COMPLEN: begin
                        owe_req = 1'b1; owe_val = {16'd0, v[7:0]} + 24'd2;
                        ec_req = 1'b1; ec_ph = PH_COMP; ec_n = {8'd0, v[7:0]};
                     end
                     PH_EXTLEN: begin
                        owe_req = 1'b1; owe_val = v;
                        if (v[15:0] == '0) fail_now = 1'b1;
                        else begin
                           erl_in = 18'(v[15:0]);
                           ext_next = 1'b1;
                        end
                     end
                     PH_SCIPHER: begin
                        item_valid = 1'b1; item_kind = KIND_CIPHER; item_value = v[15:0];
                        sf_req = 1'b1; sf_ph = PH_SCOMP;
                     end
                     PH_SCOMP: begin
                        sf_req = 1'b1; sf_ph = PH_SEXTLEN;
                     end
                     PH_SEXTLEN: begin
                        owe_req = 1'b1; owe_val = v;
                        erl_in = 18'(v[15:0]);
                        ext_next = 1'b1;
                     end
                     PH_EXTTYPE: begin
                        cek_in = v[15:0];
                        sf_req = 1'b1; sf_ph = PH_EXTLN;
                     end
                     PH_EXTLN: begin
                        erl_in = erl_ff - 18'(v[15:0]) - 18'sd4;
                        if (is_grease(cek_ff) || srv_ff) begin
                           ec_req = 1'b1; ec_ph = PH_EXTSKIP; ec_n = v[15:0];
                        end
                        if (!is_grease(cek_ff)) begin
                           item_valid = 1'b1; item_kind = KIND_EXT; item_value = cek_ff;
                           owe_req = 1'b1; owe_val = v;
                           if (!srv_ff) begin
                              case (cek_ff)
                                 EXT_SERVER_NAME: begin sf_req = 1'b1; sf_ph = PH_SNI_LIST; end
                                 EXT_GROUPS:      begin sf_req = 1'b1; sf_ph = PH_GRP_LEN; end
                                 EXT_POINT_FMTS:  begin sf_req = 1'b1; sf_ph = PH_PF_LEN; end
                                 EXT_SIG_ALGS:    begin sf_req = 1'b1; sf_ph = PH_SIG_LEN; end
                                 EXT_ALPN:        begin sf_req = 1'b1; sf_ph = PH_ALPN_LEN; end
                                 default: begin
                                    ec_req = 1'b1; ec_ph = PH_EXTSKIP; ec_n = v[15:0];
                                 end
                              endcase
                           end
                        end
                     end
                     PH_SNI_LIST: begin
                        st_in = v[15:0];
                        sf_req = 1'b1; sf_ph = PH_SNI_TYPE;
                     end
                     PH_SNI_TYPE: begin
                        sf_req = 1'b1; sf_ph = PH_SNI_LEN;
                     end
                     PH_SNI_LEN: begin
                        if (v[15:0] > SNI_MAX_LEN) fail_now = 1'b1;
                        else begin
                           owe_req = 1'b1; owe_val = v;
                           st_in = (({1'b0, v[15:0]} + 17'd3) < {1'b0, st_ff}) ?
                                   st_ff - v[15:0] - 16'd3 : 16'd0;
                           ec_req = 1'b1; ec_ph = PH_SNI_NAME; ec_n = v[15:0];
                        end
                     end
                     PH_GRP_LEN: begin
                        owe_req = 1'b1; owe_val = v;
                        ec_req = 1'b1; ec_ph = PH_GRP; ec_n = {1'b0, v[15:1]};
                     end
                     PH_PF_LEN: begin
                        owe_req = 1'b1; owe_val = v;
                        ec_req = 1'b1; ec_ph = PH_PF; ec_n = {8'd0, v[7:0]};
                     end
                     PH_SIG_LEN: begin
                        owe_req = 1'b1; owe_val = v;
                        ec_req = 1'b1; ec_ph = PH_SIG; ec_n = {1'b0, v[15:1]};
                     end
                     PH_ALPN_LEN: begin
                        owe_req = 1'b1; owe_val = v;
                        at_in  = v[15:0];
                        ac_in  = '0;
                        fap_in = 1'b1;
                        sf_req = 1'b1; sf_ph = PH_ALPN_SLEN;
                     end
                     PH_ALPN_SLEN: begin
                        ac_in = ac_ff + 17'(v[7:0]) + 17'd1;
                        ec_req = 1'b1; ec_ph = PH_ALPN_STR; ec_n = {8'd0, v[7:0]};
                     end
                     default: ;
                  endcase
               end
            end else begin
               // Counted phases: pair lists emit at most one item per two bytes.
               ill_dec = (ill_ff != '0) ? ill_ff - 16'd1 : ill_ff;
               if ((phase_ff == PH_CIPHERS || phase_ff == PH_GRP || phase_ff == PH_SIG) &&
                   fbc_ff == 2'd0) begin
                  acc_in = {8'd0, acc_new[15:0]};
                  fbc_in = 2'd1;
               end else begin
                  case (phase_ff)
                     PH_CIPHERS: begin
                        item_valid = !is_grease(pair_val);
                        item_kind  = KIND_CIPHER; item_value = pair_val;
                     end
                     PH_GRP: begin
                        item_valid = 1'b1; item_kind = KIND_GROUP; item_value = pair_val;
                     end
                     PH_SIG: begin
                        item_valid = 1'b1; item_kind = KIND_SIG; item_value = pair_val;
                     end
                     PH_SNI_NAME: begin
                        item_valid = 1'b1; item_kind = KIND_SNI;
                        item_value = {8'd0, step_byte};
                     end
                     PH_PF: begin
                        item_valid = 1'b1; item_kind = KIND_PFMT;
                        item_value = {8'd0, step_byte};
                     end
                     PH_ALPN_STR: begin
                        item_valid = fap_ff; item_kind = KIND_ALPN;
                        item_value = {8'd0, step_byte};
                     end
                     default: ;
                  endcase
                  if (phase_ff == PH_CIPHERS || phase_ff == PH_GRP || phase_ff == PH_SIG) begin
                     fbc_in = 2'd0;
                     acc_in = '0;
                  end
                  ill_in = ill_dec;
                  if (ill_dec == '0) begin
                     fin_req = 1'b1;
                     fin_ph  = phase_ff;
                  end
               end
            end
         end

         if (sf_req) begin
            phase_in = sf_ph; fbc_in = '0; acc_in = '0;
         end
         if (ec_req) begin
            phase_in = ec_ph; fbc_in = '0; acc_in = '0; ill_in = ec_n;
            if (ec_n == '0) begin
               fin_req = 1'b1;
               fin_ph  = ec_ph;
            end
         end
         if (owe_req && owe_val > bo_in) bo_in = owe_val;

         // Continuation once a counted phase has taken all of its bytes.
         if (fin_req) begin
            case (fin_ph)
               PH_RANDOM:  begin phase_in = PH_SIDLEN; fbc_in = '0; acc_in = '0; end
               PH_SID: begin
                  phase_in = srv_in ? PH_SCIPHER : PH_CSLEN; fbc_in = '0; acc_in = '0;
               end
               PH_CIPHERS: begin phase_in = PH_COMPLEN; fbc_in = '0; acc_in = '0; end
               PH_COMP:    begin phase_in = PH_EXTLEN; fbc_in = '0; acc_in = '0; end
               PH_SNI_NAME: begin
                  if (st_in != '0) begin
                     phase_in = PH_EXTSKIP; fbc_in = '0; ill_in = st_in;
                  end else ext_next = 1'b1;
               end
               PH_ALPN_STR: begin
                  fap_in = 1'b0;
                  if (ac_in < {1'b0, at_in}) begin
                     phase_in = PH_ALPN_SLEN; fbc_in = '0; acc_in = '0;
                  end else ext_next = 1'b1;
               end
               default: ext_next = 1'b1;
            endcase
         end
         if (ext_next) begin
            if (erl_in >= 18'sd4) begin
               phase_in = PH_EXTTYPE; fbc_in = '0; acc_in = '0;
            end else phase_in = PH_DONE;
         end

         accept_now = !fail_now && (phase_in == PH_DONE) && (bo_in == '0);
         vg_in = fail_now || accept_now;
      end

      // Item fields are taken before the end-of-packet clear below.
      it_item.kind          = item_kind;
      it_item.value         = item_value;
      it_item.is_server     = srv_in;
      it_item.rec_version   = '0;
      it_item.hello_version = '0;
      it_item.last          = 1'b0;

      eop_reject = step_valid && step_eop && !vg_in;
      verd_valid = fail_now || accept_now || eop_reject;
      it_verd.kind          = accept_now ? KIND_ACCEPT : KIND_REJECT;
      it_verd.value         = '0;
      it_verd.is_server     = srv_in;
      it_verd.rec_version   = accept_now ? rv_in : 16'd0;
      it_verd.hello_version = accept_now ? hv_in : 16'd0;
      it_verd.last          = 1'b1;

      if (step_valid && step_eop) begin
         phase_in = PH_TYPE;
         fbc_in   = '0;
         acc_in   = '0;
         erl_in   = '0;
         ill_in   = '0;
         cek_in   = '0;
         ac_in    = '0;
         fap_in   = 1'b1;
         srv_in   = 1'b0;
         rv_in    = '0;
         hv_in    = '0;
         vg_in    = 1'b0;
         bo_in    = '0;
         at_in    = '0;
         st_in    = '0;
      end

      push_cnt = 2'(item_valid) + 2'(verd_valid);
      push0    = item_valid ? it_item : it_verd;
      push1    = it_verd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE;
         fbc_ff   <= '0;
         acc_ff   <= '0;
         erl_ff   <= '0;
         ill_ff   <= '0;
         cek_ff   <= '0;
         ac_ff    <= '0;
         fap_ff   <= 1'b1;
         srv_ff   <= 1'b0;
         rv_ff    <= '0;
         hv_ff    <= '0;
         vg_ff    <= 1'b0;
         bo_ff    <= '0;
         at_ff    <= '0;
         st_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         fbc_ff   <= fbc_in;
         acc_ff   <= acc_in;
         erl_ff   <= erl_in;
         ill_ff   <= ill_in;
         cek_ff   <= cek_in;
         ac_ff    <= ac_in;
         fap_ff   <= fap_in;
         srv_ff   <= srv_in;
         rv_ff    <= rv_in;
         hv_ff    <= hv_in;
         vg_ff    <= vg_in;
         bo_ff    <= bo_in;
         at_ff    <= at_in;
         st_ff    <= st_in;
      end
   end

endmodule

@@ design/thfe_checker.sv @@
// Port-level checks for the TLS hello field extractor, bound to the top level.
`include "assert_macros.svh"

module thfe_checker
   import thfe_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_data_byte,
   input logic        req_end_of_packet,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_item_kind,
   input logic [15:0] rsp_item_value,
   input logic        rsp_hello_is_server,
   input logic [15:0] rsp_record_version,
   input logic [15:0] rsp_hello_version,
   input logic        rsp_verdict_last
);

   `THFE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item_kind) && $stable(rsp_item_value) && $stable(rsp_verdict_last), "result changed while stalled")
   `THFE_ASSERT(a_last_marks_verdict, !rsp_valid || (rsp_verdict_last == (rsp_item_kind == KIND_ACCEPT || rsp_item_kind == KIND_REJECT)), "verdict flag does not match item kind")
   `THFE_ASSERT(a_versions_on_accept, !rsp_valid || rsp_item_kind == KIND_ACCEPT || (rsp_record_version == 16'd0 && rsp_hello_version == 16'd0), "versions shown outside an accept")
   `THFE_ASSERT(a_verdict_value_zero, !rsp_valid || !rsp_verdict_last || rsp_item_value == 16'd0, "verdict transaction carries a value")

endmodule

bind tls_hello_field_extractor thfe_checker u_thfe_checker (.*);

@@ tb/tls_hello_field_extractor_chk.sv @@
// Checker that predicts the extractor's items and compares them with its output.
`timescale 1ns / 1ps
module tls_hello_field_extractor_chk
   import thfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_packet,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_item_kind,
   input  logic [15:0] rsp_item_value,
   input  logic        rsp_hello_is_server,
   input  logic [15:0] rsp_record_version,
   input  logic [15:0] rsp_hello_version,
   input  logic        rsp_verdict_last,
   output int          mismatches,
   output int          pending
);

   item_type    want_q[$];
   phase_type   ph;
   int unsigned fcnt, facc, inner, cur_ext, alpn_used, alpn_len, owed, sni_rest;
   int          ext_left;
   bit          alpn_first, srv, judged;
   logic [15:0] rver, hver;
   int          n_this_byte;

   assign pending = want_q.size();

   function automatic int hdr_bytes(phase_type p);
      case (p)
         PH_TYPE, PH_MTYPE, PH_SIDLEN, PH_COMPLEN, PH_SCOMP, PH_SNI_TYPE,
         PH_PF_LEN, PH_ALPN_SLEN: return 1;
         PH_RVER, PH_CLEN, PH_HVER, PH_CSLEN, PH_EXTLEN, PH_SCIPHER,
         PH_SEXTLEN, PH_EXTTYPE, PH_EXTLN, PH_SNI_LIST, PH_SNI_LEN,
         PH_GRP_LEN, PH_SIG_LEN, PH_ALPN_LEN: return 2;
         PH_MLEN: return 3;
         default: return 0;
      endcase
   endfunction

   function automatic bit grease_code(int unsigned v);
      return ((v & 16'h0f0f) == 16'h0a0a) && (v[15:8] == v[7:0]);
   endfunction

   task clear_parse();
      ph = PH_TYPE; fcnt = 0; facc = 0; ext_left = 0; inner = 0; cur_ext = 0;
      alpn_used = 0; alpn_first = 1; srv = 0; rver = 0; hver = 0; judged = 0;
      owed = 0; alpn_len = 0; sni_rest = 0;
   endtask

   task push_item(logic [3:0] kind, int unsigned value);
      item_type it;
      bit verdict;
      verdict = (kind == KIND_ACCEPT) || (kind == KIND_REJECT);
      if (n_this_byte >= 2) return;
      it.kind = kind;
      it.value = verdict ? 16'd0 : value[15:0];
      it.is_server = srv;
      it.rec_version = (kind == KIND_ACCEPT) ? rver : 16'd0;
      it.hello_version = (kind == KIND_ACCEPT) ? hver : 16'd0;
      it.last = verdict;
      want_q.push_back(it);
      n_this_byte++;
   endtask

   task reject();
      if (judged) return;
      push_item(KIND_REJECT, 0);
      judged = 1;
   endtask

   task need(int unsigned n);
      if (n > owed) owed = n & 24'hffffff;
   endtask

   task begin_field(phase_type p);
      ph = p; fcnt = 0; facc = 0;
   endtask

   task next_ext();
      if (ext_left >= 4) begin_field(PH_EXTTYPE);
      else ph = PH_DONE;
   endtask

   // Continuation once a counted phase has taken all of its bytes.
   task counted_done(phase_type p);
      case (p)
         PH_RANDOM: begin_field(PH_SIDLEN);
         PH_SID: begin_field(srv ? PH_SCIPHER : PH_CSLEN);
         PH_CIPHERS: begin_field(PH_COMPLEN);
         PH_COMP: begin_field(PH_EXTLEN);
         PH_SNI_NAME: begin
            if (sni_rest != 0) begin
               ph = PH_EXTSKIP; fcnt = 0; inner = sni_rest;
            end else next_ext();
         end
         PH_ALPN_STR: begin
            alpn_first = 0;
            if (alpn_used < alpn_len) begin_field(PH_ALPN_SLEN);
            else next_ext();
         end
         default: next_ext();
      endcase
   endtask

   task start_counted(phase_type p, int unsigned n);
      ph = p; fcnt = 0; facc = 0; inner = n;
      if (n == 0) counted_done(p);
   endtask

   function automatic bit base_version(int unsigned v);
      return v == VER_SSL2 || (v >= VER_SSL3 && v <= VER_TLS12);
   endfunction

   task header_field(int unsigned v);
      case (ph)
         PH_TYPE: if (v != REC_HANDSHAKE) reject(); else begin_field(PH_RVER);
         PH_RVER: begin
            rver = v[15:0];
            if (base_version(v)) begin_field(PH_CLEN); else reject();
         end
         PH_CLEN: begin need(v); begin_field(PH_MTYPE); end
         PH_MTYPE: begin
            if (v == HS_CLIENT_HELLO) begin srv = 0; begin_field(PH_MLEN); end
            else if (v == HS_SERVER_HELLO) begin srv = 1; begin_field(PH_MLEN); end
            else reject();
         end
         PH_MLEN: begin need(v); begin_field(PH_HVER); end
         PH_HVER: begin
            hver = v[15:0];
            if (base_version(v) || (v == VER_TLS13 && !srv)) start_counted(PH_RANDOM, 32);
            else reject();
         end
         PH_SIDLEN: begin need(v + (srv ? 5 : 2)); start_counted(PH_SID, v); end
         PH_CSLEN: begin
            need(v + 1);
            if ((v >> 1) == 0) reject(); else start_counted(PH_CIPHERS, v >> 1);
         end
         PH_COMPLEN: begin need(v + 2); start_counted(PH_COMP, v); end
         PH_EXTLEN: begin
            need(v);
            if (v == 0) reject();
            else begin ext_left = v; next_ext(); end
         end
         PH_SCIPHER: begin push_item(KIND_CIPHER, v); begin_field(PH_SCOMP); end
         PH_SCOMP: begin_field(PH_SEXTLEN);
         PH_SEXTLEN: begin need(v); ext_left = v; next_ext(); end
         PH_EXTTYPE: begin cur_ext = v; begin_field(PH_EXTLN); end
         PH_EXTLN: begin
            ext_left -= 4 + v;
            if (grease_code(cur_ext)) start_counted(PH_EXTSKIP, v);
            else begin
               push_item(KIND_EXT, cur_ext);
               need(v);
               if (srv) start_counted(PH_EXTSKIP, v);
               else case (cur_ext[15:0])
                  EXT_SERVER_NAME: begin_field(PH_SNI_LIST);
                  EXT_GROUPS: begin_field(PH_GRP_LEN);
                  EXT_POINT_FMTS: begin_field(PH_PF_LEN);
                  EXT_SIG_ALGS: begin_field(PH_SIG_LEN);
                  EXT_ALPN: begin_field(PH_ALPN_LEN);
                  default: start_counted(PH_EXTSKIP, v);
               endcase
            end
         end
         PH_SNI_LIST: begin sni_rest = v; begin_field(PH_SNI_TYPE); end
         PH_SNI_TYPE: begin_field(PH_SNI_LEN);
         PH_SNI_LEN: begin
            if (v > SNI_MAX_LEN) reject();
            else begin
               need(v);
               sni_rest = (v + 3 < sni_rest) ? sni_rest - v - 3 : 0;
               start_counted(PH_SNI_NAME, v);
            end
         end
         PH_GRP_LEN: begin need(v); start_counted(PH_GRP, v >> 1); end
         PH_PF_LEN: begin need(v); start_counted(PH_PF, v); end
         PH_SIG_LEN: begin need(v); start_counted(PH_SIG, v >> 1); end
         PH_ALPN_LEN: begin
            need(v); alpn_len = v; alpn_used = 0; alpn_first = 1;
            begin_field(PH_ALPN_SLEN);
         end
         PH_ALPN_SLEN: begin alpn_used += v + 1; start_counted(PH_ALPN_STR, v); end
         default: ;
      endcase
   endtask

   task parse_byte(logic [7:0] b);
      phase_type p;
      p = ph;
      if (p == PH_DONE) return;
      if (hdr_bytes(p) != 0) begin
         facc = ((facc << 8) | b) & 24'hffffff;
         fcnt++;
         if (fcnt >= hdr_bytes(p)) header_field(facc);
         return;
      end
      if (p == PH_CIPHERS || p == PH_GRP || p == PH_SIG) begin
         facc = ((facc << 8) | b) & 16'hffff;
         fcnt++;
         if (fcnt < 2) return;
         fcnt = 0;
         if (p == PH_CIPHERS) begin
            if (!grease_code(facc)) push_item(KIND_CIPHER, facc);
         end else push_item(p == PH_GRP ? KIND_GROUP : KIND_SIG, facc);
         facc = 0;
      end else if (p == PH_SNI_NAME) push_item(KIND_SNI, b);
      else if (p == PH_PF) push_item(KIND_PFMT, b);
      else if (p == PH_ALPN_STR && alpn_first) push_item(KIND_ALPN, b);
      if (inner > 0) inner--;
      if (inner == 0) counted_done(p);
   endtask

   task predict_byte(logic [7:0] b, logic eop);
      n_this_byte = 0;
      if (!judged) begin
         if (owed > 0) owed--;
         parse_byte(b);
         if (!judged && ph == PH_DONE && owed == 0) begin
            push_item(KIND_ACCEPT, 0);
            judged = 1;
         end
      end
      if (eop) begin
         if (!judged) reject();
         clear_parse();
      end
   endtask

   always @(posedge clock) begin
      item_type got, want;
      if (reset) begin
         clear_parse();
         want_q.delete();
         mismatches <= 0;
      end else begin
         if (req_valid && req_ready) predict_byte(req_data_byte, req_end_of_packet);
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_item_kind, rsp_item_value, rsp_hello_is_server,
                    rsp_record_version, rsp_hello_version, rsp_verdict_last};
            if (want_q.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected item kind=%0d value=%h", $time,
                           got.kind, got.value);
               mismatches <= mismatches + 1;
            end else begin
               want = want_q.pop_front();
               if (got !== want) begin
                  if (mismatches < 10)
                     $display({"%0t: item mismatch kind %0d/%0d value %h/%h srv %0d/%0d",
                               " rver %h/%h hver %h/%h last %0d/%0d (expected/actual)"},
                              $time, want.kind, got.kind, want.value, got.value,
                              want.is_server, got.is_server, want.rec_version,
                              got.rec_version, want.hello_version, got.hello_version,
                              want.last, got.last);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

endmodule

@@ tb/tls_hello_field_extractor_tb.sv @@
// Top of the extractor testbench: clock, reset, packet stimulus and the verdict.
`timescale 1ns / 1ps
module tls_hello_field_extractor_tb;
   import thfe_pkg::*;

   logic        clock, reset;
   logic        req_valid, req_ready, req_end_of_packet;
   logic [7:0]  req_data_byte;
   logic        rsp_valid, rsp_ready;
   logic [3:0]  rsp_item_kind;
   logic [15:0] rsp_item_value, rsp_record_version, rsp_hello_version;
   logic        rsp_hello_is_server, rsp_verdict_last;
   int          mismatches, pending;

   logic [7:0]  pkt[$];
   int          bytes_sent;
   bit          calm;

   tls_hello_field_extractor u_dut (.*);
   tls_hello_field_extractor_chk u_chk (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic void add16(ref logic [7:0] q[$], input int v);
      q.push_back(v[15:8]);
      q.push_back(v[7:0]);
   endfunction

   function automatic void add_rand(ref logic [7:0] q[$], input int n);
      repeat (n) q.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic int pick_version();
      int vers[6] = '{VER_SSL2, VER_SSL3, 16'h0301, 16'h0302, VER_TLS12, VER_TLS13};
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535);
      return vers[$urandom_range(0, 5)];
   endfunction

   function automatic int grease_value();
      logic [7:0] g;
      g = {4'($urandom_range(0, 15)), 4'ha};
      return {g, g};
   endfunction

   function automatic void add_ext(ref logic [7:0] q[$]);
      logic [7:0] body[$];
      int typ, n, k;
      case ($urandom_range(0, 6))
         0: begin
            typ = EXT_SERVER_NAME;
            n = ($urandom_range(0, 40) == 0) ? 256 : $urandom_range(0, 12);
            k = ($urandom_range(0, 3) == 0) ? 4 : 0;
            add16(body, n + 3 + k);
            body.push_back(8'd0);
            add16(body, n);
            add_rand(body, n + k);
         end
         1, 3: begin
            typ = ($urandom_range(0, 1) != 0) ? EXT_GROUPS : EXT_SIG_ALGS;
            n = 2 * $urandom_range(0, 4) + ($urandom_range(0, 4) == 0);
            add16(body, n);
            add_rand(body, n);
         end
         2: begin
            typ = EXT_POINT_FMTS;
            n = $urandom_range(0, 3);
            body.push_back(8'(n));
            add_rand(body, n);
         end
         4: begin
            logic [7:0] names[$];
            typ = EXT_ALPN;
            repeat ($urandom_range(1, 2)) begin
               n = $urandom_range(1, 5);
               names.push_back(8'(n));
               add_rand(names, n);
            end
            add16(body, names.size());
            body = {body, names};
         end
         5: begin typ = grease_value(); add_rand(body, $urandom_range(0, 3)); end
         default: begin typ = $urandom_range(0, 65535); add_rand(body, $urandom_range(0, 4)); end
      endcase
      add16(q, typ);
      add16(q, body.size());
      q = {q, body};
   endfunction

   // Builds a mostly well-formed hello record into pkt, with occasional damage.
   task make_hello(bit server);
      logic [7:0] h[$], exts[$];
      int n;
      add16(h, pick_version());
      add_rand(h, 32);
      n = $urandom_range(0, 4);
      h.push_back(8'(n));
      add_rand(h, n);
      repeat ($urandom_range(0, 4)) add_ext(exts);
      if (server) begin
         add_rand(h, 3);
      end else begin
         n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
         add16(h, 2 * n);
         repeat (n) add16(h, ($urandom_range(0, 2) == 0) ? grease_value()
                                                          : $urandom_range(0, 65535));
         n = $urandom_range(1, 2);
         h.push_back(8'(n));
         add_rand(h, n);
      end
      add16(h, exts.size());
      h = {h, exts};
      pkt.delete();
      pkt.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                 : REC_HANDSHAKE);
      add16(pkt, pick_version());
      add16(pkt, h.size() + 4);
      pkt.push_back(server ? HS_SERVER_HELLO : HS_CLIENT_HELLO);
      pkt.push_back(8'd0);
      add16(pkt, h.size());
      pkt = {pkt, h};
      case ($urandom_range(0, 7))
         0: pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom_range(0, 255));
         1: pkt = pkt[0 : $urandom_range(0, pkt.size() - 1)];
         2: add_rand(pkt, $urandom_range(1, 5));
         default: ;
      endcase
   endtask

   task send_packet();
      int gap;
      foreach (pkt[i]) begin
         gap = calm ? 0 : $urandom_range(0, 19);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(negedge clock);
         end
         req_valid <= 1;
         req_data_byte <= pkt[i];
         req_end_of_packet <= (i == pkt.size() - 1);
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         @(negedge clock);
         bytes_sent++;
      end
   endtask

   // Result side: random stalls per transaction, none while calm.
   initial begin
      int gap;
      rsp_ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 19);
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      reset = 1;
      req_valid = 0;
      req_data_byte = 0;
      req_end_of_packet = 0;
      bytes_sent = 0;
      calm = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // Short directed packets: bad record type, lone byte, bad versions, bad message type.
      pkt = '{8'h00};                                         send_packet();
      pkt = '{8'hff, 8'h16};                                  send_packet();
      pkt = '{REC_HANDSHAKE};                                 send_packet();
      pkt = '{REC_HANDSHAKE, 8'h03, 8'h05, 8'h00};            send_packet();
      pkt = '{REC_HANDSHAKE, 8'h00, 8'h02, 8'h00, 8'h10, 8'h07}; send_packet();
      pkt = '{REC_HANDSHAKE, 8'h03, 8'h03, 8'hff, 8'hff, HS_SERVER_HELLO,
              8'h00, 8'h00, 8'h40, 8'h03, 8'h04};             send_packet();
      while (bytes_sent < 2000) begin
         calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0) begin
            pkt.delete();
            add_rand(pkt, $urandom_range(1, 8));
         end else make_hello($urandom_range(0, 2) == 0);
         send_packet();
      end
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("tls_hello_field_extractor_tb: done, clean");
      else
         $display("tls_hello_field_extractor_tb: done, errors");
      $finish;
   end

   initial begin
      #50ms;
      $display("tls_hello_field_extractor_tb: done, errors");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/thfe_pkg.sv
design/thfe_rsp_fifo.sv
design/thfe_parser.sv
design/tls_hello_field_extractor.sv
design/thfe_checker.sv
tb/tls_hello_field_extractor_chk.sv
tb/tls_hello_field_extractor_tb.sv
